// ===== rtl/wmts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wmts_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd0;
   localparam logic [2:0] REG_KICK_TICKS     = 3'd1;
   localparam logic [2:0] REG_KICK_DUTY      = 3'd2;
   localparam logic [2:0] REG_HOLD_DUTY      = 3'd3;
   localparam logic [2:0] REG_PWM_PERIOD     = 3'd4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   // Register reset values.
   localparam logic [15:0] RST_DEBOUNCE_TICKS = 16'd50;
   localparam logic [15:0] RST_KICK_TICKS     = 16'd200;
   localparam logic [6:0]  RST_KICK_DUTY      = 7'd50;
   localparam logic [6:0]  RST_HOLD_DUTY      = 7'd30;
   localparam logic [16:0] RST_PWM_PERIOD     = 17'd4200;

   // Motion codes.
   localparam logic [1:0] MOTION_IDLE = 2'd0;
   localparam logic [1:0] MOTION_UP   = 2'd1;
   localparam logic [1:0] MOTION_DOWN = 2'd2;

   // Duty is a percentage, clamped to full scale.
   localparam logic [6:0] DUTY_FULL = 7'd100;

   // Product of period and duty, below 2^24, and the reciprocal of 100
   // scaled by 2^30 (rounded up); exact for every product in range.
   localparam int          PROD_W      = 24;
   localparam int          RECIP_SHIFT = 30;
   localparam logic [23:0] RECIP_100   = 24'd10737419;

   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [15:0] kick_ticks;
      logic [6:0]  kick_duty;
      logic [6:0]  hold_duty;
      logic [16:0] pwm_period;
   } cfg_type;

   // Result of the control pass, before the compare value is scaled.
   typedef struct packed {
      logic [1:0]        motion;
      logic              press_accepted;
      logic              kick_active;
      logic [PROD_W-1:0] product;
   } stage_type;

endpackage

`default_nettype wire

// ===== rtl/wmts_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wmts_csr import wmts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   // Register file; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= RST_DEBOUNCE_TICKS;
         cfg_ff.kick_ticks     <= RST_KICK_TICKS;
         cfg_ff.kick_duty      <= RST_KICK_DUTY;
         cfg_ff.hold_duty      <= RST_HOLD_DUTY;
         cfg_ff.pwm_period     <= RST_PWM_PERIOD;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_DEBOUNCE_TICKS: cfg_ff.debounce_ticks <= csr_wdata[15:0];
            REG_KICK_TICKS:     cfg_ff.kick_ticks     <= csr_wdata[15:0];
            REG_KICK_DUTY:      cfg_ff.kick_duty      <= csr_wdata[6:0];
            REG_HOLD_DUTY:      cfg_ff.hold_duty      <= csr_wdata[6:0];
            REG_PWM_PERIOD:     cfg_ff.pwm_period     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== rtl/wmts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wmts_ctrl import wmts_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire logic    button_level,
   input  wire cfg_type cfg,
   output stage_type    stage
);

   // Counters saturate at 2^COUNT_BITS - 1, never beyond 16 bits.
   localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   logic [1:0]       motion_ff, motion_in;
   logic             next_up_ff, next_up_in;
   logic             last_button_ff;
   logic [CNT_W-1:0] since_ff, since_in;
   logic [CNT_W-1:0] timer_ff, timer_in;
   logic             kicking_ff, kicking_in;
   stage_type        stage_ff, stage_in;

   logic [CNT_W-1:0] since_inc;
   logic             accepted;
   logic             started;
   logic [6:0]       duty_raw;
   logic [6:0]       duty;

   // Debounce, motion toggle and kick timing for one tick.
   always_comb begin
      since_inc  = (since_ff == CNT_MAX) ? since_ff : since_ff + 1'b1;
      accepted   = button_level && !last_button_ff &&
                   (16'(since_inc) >= cfg.debounce_ticks);
      since_in   = accepted ? '0 : since_inc;
      motion_in  = motion_ff;
      next_up_in = next_up_ff;
      kicking_in = kicking_ff;
      timer_in   = timer_ff;
      started    = 1'b0;

      if (accepted) begin
         if (motion_ff == MOTION_IDLE) begin
            motion_in  = next_up_ff ? MOTION_UP : MOTION_DOWN;
            kicking_in = 1'b1;
            timer_in   = '0;
            started    = 1'b1;
         end else begin
            motion_in  = MOTION_IDLE;
            next_up_in = !next_up_ff;
            kicking_in = 1'b0;
         end
      end

      // The start tick counts as elapsed zero.
      if (motion_in != MOTION_IDLE && kicking_in) begin
         if (!started) begin
            timer_in = (timer_ff == CNT_MAX) ? timer_ff : timer_ff + 1'b1;
         end
         if (16'(timer_in) >= cfg.kick_ticks) begin
            kicking_in = 1'b0;
         end
      end

      // Duty select and clamp; idle drives zero.
      duty_raw = kicking_in ? cfg.kick_duty : cfg.hold_duty;
      duty     = (duty_raw > DUTY_FULL) ? DUTY_FULL : duty_raw;
      if (motion_in == MOTION_IDLE) begin
         duty = '0;
      end

      stage_in.motion         = motion_in;
      stage_in.press_accepted = accepted;
      stage_in.kick_active    = (motion_in != MOTION_IDLE) && kicking_in;
      stage_in.product        = PROD_W'(cfg.pwm_period) * PROD_W'(duty);
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff      <= MOTION_IDLE;
         next_up_ff     <= 1'b1;
         last_button_ff <= 1'b0;
         since_ff       <= '0;
         timer_ff       <= '0;
         kicking_ff     <= 1'b0;
      end else if (fire) begin
         motion_ff      <= motion_in;
         next_up_ff     <= next_up_in;
         last_button_ff <= button_level;
         since_ff       <= since_in;
         timer_ff       <= timer_in;
         kicking_ff     <= kicking_in;
      end
   end

   // Stage payload, loaded with each accepted item.
   always_ff @(posedge clock) begin
      if (fire) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

`default_nettype wire

// ===== rtl/wmts_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wmts_scale import wmts_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        stage_valid,
   input  wire stage_type   stage,
   output logic             take,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata
);

   localparam int MUL_W = 2 * PROD_W;

   logic              valid_ff;
   logic [23:0]       data_ff, data_in;
   logic [MUL_W-1:0]  scaled;
   logic [16:0]       compare;

   // The result register can load when empty or being drained.
   assign take = !valid_ff || rsp_tready;

   // Divide the product by 100 through its reciprocal, then pack.
   always_comb begin
      scaled  = MUL_W'(stage.product) * MUL_W'(RECIP_100);
      compare = scaled[RECIP_SHIFT +: 17];
      data_in = {1'b0,
                 stage.kick_active,
                 stage.press_accepted,
                 stage.motion,
                 compare,
                 stage.motion == MOTION_DOWN,
                 stage.motion == MOTION_UP};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= stage_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && stage_valid) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/window_motor_toggle_soft_start.sv =====
// A tick is registered in the first stage, then in the result stage read on rsp_tdata.
// Throughput: one tick per cycle unless rsp_tready stalls; the control pass with the
// period-duty multiply fills one stage, the reciprocal divide by 100 the next.
// Reset (synchronous, active high) restores the register defaults, idles the
// motor with the next start going up, and empties both stages.
`timescale 1ns / 1ps
`default_nettype none

module window_motor_toggle_soft_start import wmts_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,  // [0] button_level, [7:1] zero
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] drive_up, [1] drive_down, [18:2] pwm_compare, [20:19] motion_state,
   // [21] press_accepted, [22] kick_active, [23] zero
   output logic [23:0]                rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type   cfg;
   stage_type stage;
   logic      stage_valid_ff;
   logic      take;
   logic      fire;

   // The first stage moves on when it is empty or the result stage takes it.
   assign req_tready = !stage_valid_ff || take;
   assign fire       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   wmts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wmts_ctrl #(
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .button_level (req_tdata[0]),
      .cfg          (cfg),
      .stage        (stage)
   );

   wmts_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .stage       (stage),
      .take        (take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // A full first stage reaches the output when the result stage can take it.
   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && take |=> rsp_tvalid)
      else $error("stage item lost on its way to the output");

   // Kick duty is only reported while the motor moves.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[20:19] != MOTION_IDLE)
      else $error("kick active while idle");

   // An idle motor drives nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20:19] == MOTION_IDLE |->
         rsp_tdata[18:2] == 17'd0 && rsp_tdata[1:0] == 2'b00)
      else $error("idle result drives the bridge");

   // The direction bits follow the motion code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[20:19] == MOTION_UP) &&
                     rsp_tdata[1] == (rsp_tdata[20:19] == MOTION_DOWN))
      else $error("drive bits disagree with motion state");

endmodule

`default_nettype wire

// ===== tb/motor_drive_checker.sv =====
`timescale 1ns / 1ps

module motor_drive_checker import wmts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [7:0]            req_tdata,  // [0] button_level, [7:1] zero
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] drive_up, [1] drive_down, [18:2] pwm_compare, [20:19] motion_state,
   // [21] press_accepted, [22] kick_active, [23] zero
   input  wire logic [23:0]           rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatch_count,
   output int                         pending_items
);

   // Elapsed counters stop here (16 bit counters).
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // One drive result; the first member sits in the highest bits.
   typedef struct packed {
      logic        kick_active;
      logic        press_accepted;
      logic [1:0]  motion_state;
      logic [16:0] pwm_compare;
      logic        drive_down;
      logic        drive_up;
   } drive_result_type;

   cfg_type          regs;
   logic [1:0]       motion;
   logic             next_up;
   logic             last_button;
   logic [15:0]      since_press;
   logic [15:0]      kick_timer;
   logic             kicking;
   drive_result_type expected_drive[$];
   int               errors = 0;

   // Compare value for a duty percent; duties above full scale are clamped.
   function automatic logic [16:0] scaled_compare(logic [6:0] duty, logic [16:0] period);
      logic [6:0]  clamped;
      logic [31:0] product;
      clamped = (duty > DUTY_FULL) ? DUTY_FULL : duty;
      product = 32'(period) * 32'(clamped);
      return 17'(product / 32'(DUTY_FULL));
   endfunction

   function automatic logic [15:0] count_up(logic [15:0] value);
      return (value == COUNT_MAX) ? COUNT_MAX : value + 16'd1;
   endfunction

   // Advance the motor controller by one tick and form its result.
   task automatic predict_tick(input logic button, output drive_result_type res);
      logic accepted;
      logic started;
      accepted = 1'b0;
      started  = 1'b0;

      // Debounce runs against the already incremented count.
      since_press = count_up(since_press);
      if (button && !last_button && since_press >= regs.debounce_ticks) begin
         accepted    = 1'b1;
         since_press = '0;
      end
      last_button = button;

      // A press starts an idle motor or stops a moving one.
      if (accepted) begin
         if (motion == MOTION_IDLE) begin
            motion     = next_up ? MOTION_UP : MOTION_DOWN;
            kicking    = 1'b1;
            kick_timer = '0;
            started    = 1'b1;
         end else begin
            motion  = MOTION_IDLE;
            next_up = !next_up;
            kicking = 1'b0;
         end
      end

      // The start tick counts as elapsed zero; the kick ends once the count
      // reaches kick_ticks.
      if (motion != MOTION_IDLE && kicking) begin
         if (!started) kick_timer = count_up(kick_timer);
         if (kick_timer >= regs.kick_ticks) kicking = 1'b0;
      end

      res.drive_up       = (motion == MOTION_UP);
      res.drive_down     = (motion == MOTION_DOWN);
      res.motion_state   = motion;
      res.press_accepted = accepted;
      res.kick_active    = (motion != MOTION_IDLE) && kicking;
      if (motion == MOTION_IDLE) begin
         res.pwm_compare = '0;
      end else begin
         res.pwm_compare = scaled_compare(kicking ? regs.kick_duty : regs.hold_duty,
                                          regs.pwm_period);
      end
   endtask

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endfunction

   // Results are checked before the new tick is predicted in the same cycle.
   always @(posedge clock) begin
      drive_result_type got;
      drive_result_type want;
      drive_result_type predicted;
      if (reset) begin
         regs.debounce_ticks = RST_DEBOUNCE_TICKS;
         regs.kick_ticks     = RST_KICK_TICKS;
         regs.kick_duty      = RST_KICK_DUTY;
         regs.hold_duty      = RST_HOLD_DUTY;
         regs.pwm_period     = RST_PWM_PERIOD;
         motion      = MOTION_IDLE;
         next_up     = 1'b1;
         last_button = 1'b0;
         since_press = '0;
         kick_timer  = '0;
         kicking     = 1'b0;
         expected_drive.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = drive_result_type'(rsp_tdata[22:0]);
            if (expected_drive.size() == 0) begin
               $error("drive result arrived with no tick waiting");
               errors++;
            end else begin
               want = expected_drive.pop_front();
               check_field("drive_up", want.drive_up, got.drive_up);
               check_field("drive_down", want.drive_down, got.drive_down);
               check_field("pwm_compare", want.pwm_compare, got.pwm_compare);
               check_field("motion_state", want.motion_state, got.motion_state);
               check_field("press_accepted", want.press_accepted, got.press_accepted);
               check_field("kick_active", want.kick_active, got.kick_active);
            end
         end

         // Unknown indexes leave every register alone.
         if (csr_we) begin
            case (csr_addr)
               REG_DEBOUNCE_TICKS: regs.debounce_ticks = csr_wdata[15:0];
               REG_KICK_TICKS:     regs.kick_ticks     = csr_wdata[15:0];
               REG_KICK_DUTY:      regs.kick_duty      = csr_wdata[6:0];
               REG_HOLD_DUTY:      regs.hold_duty      = csr_wdata[6:0];
               REG_PWM_PERIOD:     regs.pwm_period     = csr_wdata[16:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[0], predicted);
            expected_drive.push_back(predicted);
         end
      end
      mismatch_count <= errors;
      pending_items  <= expected_drive.size();
   end

endmodule

// ===== tb/window_motor_toggle_soft_start_test.sv =====
`timescale 1ns / 1ps

module window_motor_toggle_soft_start_test;
   import wmts_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [23:0]           rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic steady       = 1'b0;
   logic button_level = 1'b0;
   int   run_left     = 0;
   int   cycles       = 0;
   int   mismatches;
   int   pending;

   window_motor_toggle_soft_start DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   motor_drive_checker drive_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .pending_items  (pending)
   );

   always #10 clock = ~clock;

   // The result side stalls at random unless a steady stretch is running.
   always @(negedge clock) begin
      rsp_tready = steady || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Offer one button tick, with random gaps before it, and wait until taken.
   task automatic send_tick(input logic level);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {7'd0, level};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop offering ticks and wait until every drive result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Reprogram all registers while idle, plus one write to an unused index.
   task automatic apply_settings(input logic [15:0] debounce, input logic [15:0] kick,
                                 input logic [6:0] kick_pct, input logic [6:0] hold_pct,
                                 input logic [16:0] period);
      drain();
      write_reg(REG_DEBOUNCE_TICKS, 17'(debounce));
      write_reg(REG_KICK_TICKS, 17'(kick));
      write_reg(REG_KICK_DUTY, 17'(kick_pct));
      write_reg(REG_HOLD_DUTY, 17'(hold_pct));
      write_reg(REG_PWM_PERIOD, period);
      write_reg(REG_PWM_PERIOD + 3'($urandom_range(3, 1)), 17'($urandom));
   endtask

   // Button runs: mostly held or released long enough to pass the debounce,
   // with short glitches mixed in.
   task automatic press_sequence(input int count, input int longest_run);
      repeat (count) begin
         if (run_left == 0) begin
            button_level = ~button_level;
            if ($urandom_range(99) < 20) run_left = $urandom_range(3, 1);
            else run_left = $urandom_range(longest_run, 1);
         end
         run_left--;
         send_tick(button_level);
      end
   endtask

   initial begin
      logic [19:0] pattern;
      logic [15:0] debounce;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Presses right after reset fall inside the reset debounce window.
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // Short debounce and kick: start up, kick end, stop, restart down,
      // presses that come too soon, duty clamp and a 17 bit period.
      apply_settings(16'd2, 16'd2, 7'd127, DUTY_FULL, 17'd65536);
      pattern = 20'b1100_1101_0010_1011_1010;
      for (int i = 0; i < 20; i++) send_tick(pattern[i]);

      // Register defaults.
      apply_settings(RST_DEBOUNCE_TICKS, RST_KICK_TICKS, RST_KICK_DUTY,
                     RST_HOLD_DUTY, RST_PWM_PERIOD);
      press_sequence(150, 90);

      // Lowest settings, with neither side idling.
      steady = 1'b1;
      apply_settings(16'd0, 16'd0, DUTY_FULL, 7'd0, 17'd1);
      press_sequence(150, 6);
      steady = 1'b0;

      // Highest field values: no press gets past the debounce.
      apply_settings(16'hFFFF, 16'hFFFF, 7'd127, 7'd127, 17'h1FFFF);
      press_sequence(100, 20);

      // Zero period with an endless kick.
      apply_settings(16'd5, 16'hFFFF, 7'($urandom_range(127)), 7'($urandom_range(127)),
                     17'd0);
      press_sequence(150, 12);

      // Random settings.
      repeat (3) begin
         debounce = 16'($urandom_range(30));
         apply_settings(debounce, 16'($urandom_range(40)), 7'($urandom_range(127)),
                        7'($urandom_range(127)), 17'($urandom_range(131071, 1)));
         press_sequence(150, int'(debounce) + 10);
      end

      // One tick each of debounce and kick.
      apply_settings(16'd1, 16'd1, 7'($urandom_range(100)), 7'($urandom_range(100)),
                     17'($urandom_range(65536, 1)));
      press_sequence(100, 4);

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/wmts_pkg.sv
rtl/wmts_csr.sv
rtl/wmts_ctrl.sv
rtl/wmts_scale.sv
rtl/window_motor_toggle_soft_start.sv
tb/motor_drive_checker.sv
tb/window_motor_toggle_soft_start_test.sv
